/* rtl/core/qnm_pkg.sv */
// Shared widths, term tables and inter-stage bus types for the quaternion
// normalise/multiply pipeline. No dependencies.
`timescale 1ns / 1ps

package qnm_pkg;

    localparam int CB    = 16;            // component width
    localparam int FB    = 12;            // fraction bits
    localparam int PW    = 2 * CB;        // one component product
    localparam int C_W   = PW + 2;        // sum of four products, signed
    localparam int MAG_W = C_W - 1;       // magnitude of such a sum
    localparam int LO_W  = MAG_W - 1;     // low part for the squarer
    localparam int SQ_W  = 2 * MAG_W;     // one square
    localparam int S_W   = SQ_W + 2;      // sum of four squares
    localparam int T_W   = SQ_W + 2 * FB + 2;
    localparam int Q_W   = FB + 1;        // quotient 0 .. 2^FB
    localparam int ACC_W = S_W + 2 * Q_W + 2;
    localparam int OUT_W = FB + 2;
    localparam int LATENCY = 7 + Q_W;

    // Hamilton product: term n of component n/4 is +/- a[TERM_A] * b[TERM_B]
    localparam logic [1:0] TERM_A [16] = '{2'd0, 2'd1, 2'd2, 2'd3,
                                           2'd0, 2'd1, 2'd2, 2'd3,
                                           2'd0, 2'd2, 2'd3, 2'd1,
                                           2'd0, 2'd3, 2'd1, 2'd2};
    localparam logic [1:0] TERM_B [16] = '{2'd0, 2'd1, 2'd2, 2'd3,
                                           2'd1, 2'd0, 2'd3, 2'd2,
                                           2'd2, 2'd0, 2'd1, 2'd3,
                                           2'd3, 2'd0, 2'd2, 2'd1};
    localparam logic [15:0] TERM_NEG = 16'b1000_1000_1000_1110;

    typedef enum logic {OP_MUL = 1'b0, OP_NORM = 1'b1} op_t;

    typedef struct packed {
        logic                  valid;
        logic [3:0]            neg;
        logic [3:0][MAG_W-1:0] mag;
    } mag_bus_t;

    typedef struct packed {
        logic                valid;
        logic [3:0]          neg;
        logic [3:0][T_W-1:0] t;
        logic [S_W-1:0]      s;
    } energy_bus_t;

    typedef struct packed {
        logic                valid;
        logic                zero;
        logic [3:0]          neg;
        logic [3:0][Q_W-1:0] q;
    } ratio_bus_t;

endpackage

/* rtl/core/qnm_product.sv */
// Input register, signed term products and component sums (three stages).
// Depends on qnm_pkg.
`timescale 1ns / 1ps

module qnm_product
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid,
    input  logic                        opcode,
    input  logic signed [qnm_pkg::CB-1:0] a [4],
    input  logic signed [qnm_pkg::CB-1:0] b [4],
    output qnm_pkg::mag_bus_t           bus
);

    logic                          v1_reg, v2_reg, v3_reg;
    logic                          op1_reg;
    logic signed [qnm_pkg::CB-1:0] a1_reg [4];
    logic signed [qnm_pkg::CB-1:0] b1_reg [4];
    logic signed [qnm_pkg::PW-1:0] p_reg  [16];
    logic signed [qnm_pkg::PW-1:0] p_next [16];
    logic [3:0]                    neg_reg, neg_next;
    logic [3:0][qnm_pkg::MAG_W-1:0] mag_reg, mag_next;

    always_comb
    begin
        for (int n = 0; n < 16; n++)
        begin
            if (qnm_pkg::op_t'(op1_reg) == qnm_pkg::OP_NORM)
            begin
                // normalise a: first slot of each component carries a itself
                p_next[n] = ((n % 4) == 0) ? qnm_pkg::PW'(a1_reg[n / 4])
                                           : '0;
            end
            else
            begin
                p_next[n] = qnm_pkg::PW'(a1_reg[qnm_pkg::TERM_A[n]])
                          * qnm_pkg::PW'(b1_reg[qnm_pkg::TERM_B[n]]);
                if (qnm_pkg::TERM_NEG[n])
                begin
                    p_next[n] = -p_next[n];
                end
            end
        end
    end

    always_comb
    begin
        logic signed [qnm_pkg::C_W-1:0] c;
        logic signed [qnm_pkg::C_W-1:0] c_abs;
        for (int i = 0; i < 4; i++)
        begin
            c = qnm_pkg::C_W'(p_reg[4*i]) + qnm_pkg::C_W'(p_reg[4*i+1])
              + qnm_pkg::C_W'(p_reg[4*i+2]) + qnm_pkg::C_W'(p_reg[4*i+3]);
            neg_next[i] = c[qnm_pkg::C_W-1];
            c_abs       = neg_next[i] ? -c : c;
            mag_next[i] = c_abs[qnm_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg <= opcode;
        a1_reg  <= a;
        b1_reg  <= b;
        p_reg   <= p_next;
        neg_reg <= neg_next;
        mag_reg <= mag_next;
    end

    assign bus.valid = v3_reg;
    assign bus.neg   = neg_reg;
    assign bus.mag   = mag_reg;

endmodule

/* rtl/core/qnm_energy.sv */
// Squares of the four magnitudes and their sum (three stages).
// Depends on qnm_pkg.
`timescale 1ns / 1ps

module qnm_energy
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  qnm_pkg::mag_bus_t    din,
    output qnm_pkg::energy_bus_t bus
);

    logic v4_reg, v5_reg, v6_reg;
    logic [3:0] neg4_reg, neg5_reg, neg6_reg;
    logic [3:0]                        hi_reg;
    logic [3:0][qnm_pkg::LO_W-1:0]     lo_reg;
    logic [3:0][2*qnm_pkg::LO_W-1:0]   ll_reg;
    logic [3:0][qnm_pkg::SQ_W-1:0]     sq_reg, sq_next;
    logic [3:0][qnm_pkg::T_W-1:0]      t_reg;
    logic [qnm_pkg::S_W-1:0]           s_reg;

    // (h*2^L + l)^2 = l^2 + h*(2^(L+1)*l + 2^(2L))
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sq_next[i] = qnm_pkg::SQ_W'(ll_reg[i]);
            if (hi_reg[i])
            begin
                sq_next[i] = sq_next[i]
                           + (qnm_pkg::SQ_W'(lo_reg[i]) << (qnm_pkg::LO_W + 1))
                           + (qnm_pkg::SQ_W'(1) << (2 * qnm_pkg::LO_W));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= din.valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            hi_reg[i] <= din.mag[i][qnm_pkg::MAG_W-1];
            lo_reg[i] <= din.mag[i][qnm_pkg::LO_W-1:0];
            ll_reg[i] <= (2 * qnm_pkg::LO_W)'(din.mag[i][qnm_pkg::LO_W-1:0])
                       * (2 * qnm_pkg::LO_W)'(din.mag[i][qnm_pkg::LO_W-1:0]);
            t_reg[i]  <= qnm_pkg::T_W'(sq_reg[i]) << (2 * qnm_pkg::FB + 2);
        end
        neg4_reg <= din.neg;
        neg5_reg <= neg4_reg;
        neg6_reg <= neg5_reg;
        sq_reg   <= sq_next;
        s_reg    <= qnm_pkg::S_W'(sq_reg[0]) + qnm_pkg::S_W'(sq_reg[1])
                  + qnm_pkg::S_W'(sq_reg[2]) + qnm_pkg::S_W'(sq_reg[3]);
    end

    assign bus.valid = v6_reg;
    assign bus.neg   = neg6_reg;
    assign bus.t     = t_reg;
    assign bus.s     = s_reg;

endmodule

/* rtl/core/qnm_ratio.sv */
// Bit-per-stage search for q = round(|c| * 2^FB / sqrt(S)) on four lanes.
// Keeps A = (2q-1)^2*S and B = (2q-1)*S so each step is shifts and adds.
// Depends on qnm_pkg.
`timescale 1ns / 1ps

module qnm_ratio
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  qnm_pkg::energy_bus_t din,
    output qnm_pkg::ratio_bus_t  bus
);

    localparam int N = qnm_pkg::Q_W;

    logic                                v_reg   [N];
    logic [3:0]                          neg_reg [N];
    logic [qnm_pkg::S_W-1:0]             s_reg   [N];
    logic [qnm_pkg::T_W-1:0]             t_reg   [N][4];
    logic signed [qnm_pkg::ACC_W-1:0]    acc_reg [N][4];
    logic signed [qnm_pkg::ACC_W-1:0]    crs_reg [N][4];
    logic [qnm_pkg::Q_W-1:0]             q_reg   [N][4];

    for (genvar n = 0; n < N; n++)
    begin : g_step
        localparam int K = N - 1 - n;

        logic                             v_cur;
        logic [3:0]                       neg_cur;
        logic [qnm_pkg::S_W-1:0]          s_cur;
        logic signed [qnm_pkg::ACC_W-1:0] s_ext;
        logic [qnm_pkg::T_W-1:0]          t_cur   [4];
        logic signed [qnm_pkg::ACC_W-1:0] acc_cur [4];
        logic signed [qnm_pkg::ACC_W-1:0] crs_cur [4];
        logic [qnm_pkg::Q_W-1:0]          q_cur   [4];
        logic signed [qnm_pkg::ACC_W-1:0] acc_try [4];
        logic signed [qnm_pkg::ACC_W-1:0] t_ext   [4];
        logic [3:0]                       take;

        if (n == 0)
        begin : g_first
            // q = 0, so 2q-1 = -1
            assign v_cur   = din.valid;
            assign neg_cur = din.neg;
            assign s_cur   = din.s;
            for (genvar i = 0; i < 4; i++)
            begin : g_lane
                assign t_cur[i]   = din.t[i];
                assign acc_cur[i] = qnm_pkg::ACC_W'(din.s);
                assign crs_cur[i] = -qnm_pkg::ACC_W'(din.s);
                assign q_cur[i]   = '0;
            end
        end
        else
        begin : g_next
            assign v_cur   = v_reg[n-1];
            assign neg_cur = neg_reg[n-1];
            assign s_cur   = s_reg[n-1];
            assign t_cur   = t_reg[n-1];
            assign acc_cur = acc_reg[n-1];
            assign crs_cur = crs_reg[n-1];
            assign q_cur   = q_reg[n-1];
        end

        assign s_ext = qnm_pkg::ACC_W'(s_cur);

        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                t_ext[i]   = qnm_pkg::ACC_W'(t_cur[i]);
                acc_try[i] = acc_cur[i] + (crs_cur[i] <<< (K + 2))
                           + (s_ext <<< (2 * K + 2));
                take[i]    = (acc_try[i] <= t_ext[i]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[n] <= 1'b0;
            end
            else
            begin
                v_reg[n] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            neg_reg[n] <= neg_cur;
            s_reg[n]   <= s_cur;
            t_reg[n]   <= t_cur;
            for (int i = 0; i < 4; i++)
            begin
                acc_reg[n][i] <= take[i] ? acc_try[i] : acc_cur[i];
                crs_reg[n][i] <= take[i] ? crs_cur[i] + (s_ext <<< (K + 1))
                                         : crs_cur[i];
                q_reg[n][i]   <= q_cur[i] | (qnm_pkg::Q_W'(take[i]) << K);
            end
        end
    end

    assign bus.valid = v_reg[N-1];
    assign bus.zero  = (s_reg[N-1] == '0);
    assign bus.neg   = neg_reg[N-1];

    for (genvar i = 0; i < 4; i++)
    begin : g_out
        assign bus.q[i] = q_reg[N-1][i];
    end

endmodule

/* rtl/core/quaternion_normalize_multiply.sv */
// Top level: normalised Hamilton product / normalise of signed Q3.12
// quaternions. Depends on qnm_pkg, qnm_product, qnm_energy, qnm_ratio.
//
//  channel   handshake          fields
//  input     start / busy       opcode, a_w..a_z, b_w..b_z
//  result    done (one cycle)   out_w..out_z, zero_magnitude
//
// One item per clock; busy is always low. Each item's result strobes on
// done once it has passed 7 stages plus one stage per quotient bit (13
// bits of the rounding search). Reset clears only the valid bits along
// the pipe. The receiver cannot stall, so the pipe never holds.
`timescale 1ns / 1ps

module quaternion_normalize_multiply
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               opcode,
    input  logic signed [qnm_pkg::CB-1:0]      a_w,
    input  logic signed [qnm_pkg::CB-1:0]      a_x,
    input  logic signed [qnm_pkg::CB-1:0]      a_y,
    input  logic signed [qnm_pkg::CB-1:0]      a_z,
    input  logic signed [qnm_pkg::CB-1:0]      b_w,
    input  logic signed [qnm_pkg::CB-1:0]      b_x,
    input  logic signed [qnm_pkg::CB-1:0]      b_y,
    input  logic signed [qnm_pkg::CB-1:0]      b_z,
    output logic                               done,
    output logic signed [qnm_pkg::OUT_W-1:0]   out_w,
    output logic signed [qnm_pkg::OUT_W-1:0]   out_x,
    output logic signed [qnm_pkg::OUT_W-1:0]   out_y,
    output logic signed [qnm_pkg::OUT_W-1:0]   out_z,
    output logic                               zero_magnitude
);

    logic signed [qnm_pkg::CB-1:0] a_vec [4];
    logic signed [qnm_pkg::CB-1:0] b_vec [4];
    qnm_pkg::mag_bus_t    mag_bus;
    qnm_pkg::energy_bus_t energy_bus;
    qnm_pkg::ratio_bus_t  ratio_bus;

    logic                               done_reg;
    logic                               zero_reg;
    logic signed [qnm_pkg::OUT_W-1:0]   res_reg  [4];
    logic signed [qnm_pkg::OUT_W-1:0]   res_next [4];

    assign busy  = 1'b0;
    assign a_vec = '{a_w, a_x, a_y, a_z};
    assign b_vec = '{b_w, b_x, b_y, b_z};

    qnm_product u_product
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (start & ~busy),
        .opcode (opcode),
        .a      (a_vec),
        .b      (b_vec),
        .bus    (mag_bus)
    );

    qnm_energy u_energy
    (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (mag_bus),
        .bus   (energy_bus)
    );

    qnm_ratio u_ratio
    (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (energy_bus),
        .bus   (ratio_bus)
    );

    always_comb
    begin
        logic signed [qnm_pkg::OUT_W-1:0] q;
        for (int i = 0; i < 4; i++)
        begin
            q = qnm_pkg::OUT_W'(ratio_bus.q[i]);
            if (ratio_bus.zero)
            begin
                res_next[i] = '0;
            end
            else
            begin
                res_next[i] = ratio_bus.neg[i] ? -q : q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ratio_bus.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= ratio_bus.zero;
        res_reg  <= res_next;
    end

    assign done           = done_reg;
    assign zero_magnitude = zero_reg;
    assign out_w          = res_reg[0];
    assign out_x          = res_reg[1];
    assign out_y          = res_reg[2];
    assign out_z          = res_reg[3];

endmodule

/* rtl/core/qnm_checker.sv */
// Port-level checks for the quaternion normalise/multiply block, bound to
// the top level. Depends on qnm_pkg.
`timescale 1ns / 1ps

module qnm_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             opcode,
    input logic signed [qnm_pkg::CB-1:0]    a_w,
    input logic signed [qnm_pkg::CB-1:0]    a_x,
    input logic signed [qnm_pkg::CB-1:0]    a_y,
    input logic signed [qnm_pkg::CB-1:0]    a_z,
    input logic                             done,
    input logic signed [qnm_pkg::OUT_W-1:0] out_w,
    input logic signed [qnm_pkg::OUT_W-1:0] out_x,
    input logic signed [qnm_pkg::OUT_W-1:0] out_y,
    input logic signed [qnm_pkg::OUT_W-1:0] out_z,
    input logic                             zero_magnitude
);

    localparam logic signed [qnm_pkg::OUT_W-1:0] ONE =
        qnm_pkg::OUT_W'(1) <<< qnm_pkg::FB;

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(qnm_pkg::LATENCY) done)
        else $error("result strobe missing at fixed latency");

    a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && qnm_pkg::op_t'(opcode) == qnm_pkg::OP_NORM &&
         a_w == 0 && a_x == 0 && a_y == 0 && a_z == 0)
        |-> ##(qnm_pkg::LATENCY) zero_magnitude)
        else $error("zero vector not flagged");

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_magnitude) |->
        (out_w == 0 && out_x == 0 && out_y == 0 && out_z == 0))
        else $error("zero magnitude with non-zero components");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !zero_magnitude) |->
        (out_w <= ONE && out_w >= -ONE && out_x <= ONE && out_x >= -ONE &&
         out_y <= ONE && out_y >= -ONE && out_z <= ONE && out_z >= -ONE))
        else $error("component beyond unit range");

endmodule

bind quaternion_normalize_multiply qnm_checker u_qnm_checker (.*);

/* verif/tb_top.sv */
// Testbench for quaternion_normalize_multiply: random and directed items,
// an in-bench predictor of the normalised product, and a result scoreboard.
// Depends on qnm_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        qnm_pkg::op_t       op;
        logic signed [15:0] a [4];
        logic signed [15:0] b [4];
    } quat_item_t;

    typedef struct {
        logic signed [13:0] q [4];
        logic               zero;
    } unit_quat_t;

    localparam int LIMIT_CYCLES = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic opcode = 1'b0;
    logic signed [15:0] a_w = '0, a_x = '0, a_y = '0, a_z = '0;
    logic signed [15:0] b_w = '0, b_x = '0, b_y = '0, b_z = '0;
    logic done;
    logic signed [13:0] out_w, out_x, out_y, out_z;
    logic zero_magnitude;

    quat_item_t pending_items[$];
    unit_quat_t expected_units[$];
    int  gap_left = 0;
    int  cycle_count = 0;
    int  results_seen = 0;
    int  zero_seen = 0;
    int  error_count = 0;
    bit  stimulus_done = 1'b0;

    quaternion_normalize_multiply dut
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
        .a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
        .b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .done(done), .out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .zero_magnitude(zero_magnitude)
    );

    always #1 clk = ~clk;

    // Exact arithmetic: components at most ~2^33, squares ~2^66, so 128 bits
    // hold the rounding test (2q-1)^2 * S <= 4 * c^2 * 2^24 comfortably at 200.
    function automatic unit_quat_t normalise_product(quat_item_t it);
        unit_quat_t r;
        logic signed [39:0] comp [4];
        logic [199:0] mag2, sum, lhs, rhs, t;
        logic [12:0] lo, hi, mid;
        int ai, bi;
        sum = '0;
        for (int n = 0; n < 4; n++)
        begin
            comp[n] = '0;
            if (it.op == qnm_pkg::OP_MUL)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    ai = qnm_pkg::TERM_A[4*n+k];
                    bi = qnm_pkg::TERM_B[4*n+k];
                    if (qnm_pkg::TERM_NEG[4*n+k])
                        comp[n] = comp[n] - 40'(it.a[ai]) * 40'(it.b[bi]);
                    else
                        comp[n] = comp[n] + 40'(it.a[ai]) * 40'(it.b[bi]);
                end
            end
            else
                comp[n] = 40'(it.a[n]);
            mag2 = 200'(comp[n] < 0 ? -comp[n] : comp[n]);
            sum = sum + mag2 * mag2;
        end
        r.zero = (sum == 0);
        for (int n = 0; n < 4; n++)
        begin
            r.q[n] = '0;
            if (!r.zero)
            begin
                mag2 = 200'(comp[n] < 0 ? -comp[n] : comp[n]);
                rhs = (mag2 * mag2) << 26;
                lo = 0;
                hi = 13'd4096;
                while (lo < hi)
                begin
                    mid = (lo + hi + 1) >> 1;
                    t = 200'(2 * mid - 1);
                    lhs = t * t * sum;
                    if (lhs <= rhs) lo = mid;
                    else hi = mid - 1;
                end
                r.q[n] = comp[n] < 0 ? -14'(lo) : 14'(lo);
            end
        end
        return r;
    endfunction

    function automatic quat_item_t make_item(qnm_pkg::op_t op, logic [63:0] a,
                                             logic [63:0] b);
        quat_item_t it;
        it.op = op;
        for (int k = 0; k < 4; k++)
        begin
            it.a[k] = a[16*k +: 16];
            it.b[k] = b[16*k +: 16];
        end
        return it;
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(signed'($urandom_range(0, 8)) - 4);
            4, 5: return 16'(signed'($urandom_range(0, 8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int rand_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial
    begin
        logic [63:0] ra, rb;
        // directed: extremes, both operations, zero magnitude, ties, ignored b
        pending_items.push_back(make_item(qnm_pkg::OP_NORM, 64'h0, 64'h0));
        pending_items.push_back(make_item(qnm_pkg::OP_MUL, 64'h0, 64'h0));
        pending_items.push_back(make_item(qnm_pkg::OP_MUL, 64'h1000, 64'h0));
        pending_items.push_back(make_item(qnm_pkg::OP_NORM, 64'h1000,
                                          64'hffff_ffff_ffff_ffff));
        pending_items.push_back(make_item(qnm_pkg::OP_NORM, 64'h8000_8000_8000_8000,
                                          64'h0));
        pending_items.push_back(make_item(qnm_pkg::OP_NORM, 64'h7fff_7fff_7fff_7fff,
                                          64'h0));
        pending_items.push_back(make_item(qnm_pkg::OP_MUL, 64'h8000_8000_8000_8000,
                                          64'h8000_8000_8000_8000));
        pending_items.push_back(make_item(qnm_pkg::OP_MUL, 64'h7fff_7fff_7fff_7fff,
                                          64'h8000_8000_8000_8000));
        pending_items.push_back(make_item(qnm_pkg::OP_MUL, 64'h7fff_8000_7fff_8000,
                                          64'h8000_7fff_8000_7fff));
        pending_items.push_back(make_item(qnm_pkg::OP_NORM, 64'h0001_0001_0001_0001,
                                          64'h0));
        pending_items.push_back(make_item(qnm_pkg::OP_NORM, 64'hffff_0000_0001_0000,
                                          64'h0));
        pending_items.push_back(make_item(qnm_pkg::OP_NORM, 64'h0000_0000_0000_ffff,
                                          64'h0));
        pending_items.push_back(make_item(qnm_pkg::OP_MUL, 64'h0000_0000_1000_0000,
                                          64'h0000_1000_0000_0000));
        pending_items.push_back(make_item(qnm_pkg::OP_MUL, 64'h1000_1000_1000_1000,
                                          64'hf000_1000_f000_1000));
        pending_items.push_back(make_item(qnm_pkg::OP_MUL, 64'h5555_aaaa_5555_aaaa,
                                          64'haaaa_5555_aaaa_5555));
        pending_items.push_back(make_item(qnm_pkg::OP_NORM, 64'h0003_0004_0000_0000,
                                          64'h0));
        for (int i = 0; i < 940; i++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                ra[16*k +: 16] = rand_comp();
                rb[16*k +: 16] = rand_comp();
            end
            if ($urandom_range(0, 19) == 0) ra = '0;
            pending_items.push_back(make_item(qnm_pkg::op_t'($urandom_range(0, 1)),
                                              ra, rb));
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver
    always @(negedge clk)
    begin
        quat_item_t it;
        if (rst_n)
        begin
            // hold the item while busy refuses it
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    it = pending_items.pop_front();
                    opcode <= it.op;
                    a_w <= it.a[0]; a_x <= it.a[1]; a_y <= it.a[2]; a_z <= it.a[3];
                    b_w <= it.b[0]; b_x <= it.b[1]; b_y <= it.b[2]; b_z <= it.b[3];
                    start <= 1'b1;
                    gap_left <= rand_gap();
                end
                else
                begin
                    start <= 1'b0;
                    stimulus_done <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        quat_item_t acc;
        unit_quat_t exp_u;
        cycle_count <= cycle_count + 1;
        if (rst_n && start && !busy)
        begin
            acc.op = qnm_pkg::op_t'(opcode);
            acc.a = '{a_w, a_x, a_y, a_z};
            acc.b = '{b_w, b_x, b_y, b_z};
            expected_units.push_back(normalise_product(acc));
        end
        if (rst_n && done)
        begin
            results_seen <= results_seen + 1;
            if (zero_magnitude) zero_seen <= zero_seen + 1;
            if (expected_units.size() == 0)
            begin
                $error("result with nothing expected");
                error_count = error_count + 1;
            end
            else
            begin
                exp_u = expected_units.pop_front();
                if (out_w !== exp_u.q[0])
                begin
                    $error("out_w expected %0d got %0d", exp_u.q[0], out_w);
                    error_count = error_count + 1;
                end
                if (out_x !== exp_u.q[1])
                begin
                    $error("out_x expected %0d got %0d", exp_u.q[1], out_x);
                    error_count = error_count + 1;
                end
                if (out_y !== exp_u.q[2])
                begin
                    $error("out_y expected %0d got %0d", exp_u.q[2], out_y);
                    error_count = error_count + 1;
                end
                if (out_z !== exp_u.q[3])
                begin
                    $error("out_z expected %0d got %0d", exp_u.q[3], out_z);
                    error_count = error_count + 1;
                end
                if (zero_magnitude !== exp_u.zero)
                begin
                    $error("zero_magnitude expected %0b got %0b", exp_u.zero,
                           zero_magnitude);
                    error_count = error_count + 1;
                end
            end
        end
    end

    initial
    begin
        fork
            begin
                while (!(stimulus_done && expected_units.size() == 0))
                    @(posedge clk);
                repeat (qnm_pkg::LATENCY + 10) @(posedge clk);
            end
            begin
                while (cycle_count < LIMIT_CYCLES)
                    @(posedge clk);
            end
        join_any
        if (cycle_count >= LIMIT_CYCLES)
            error_count = error_count + 1;
        $display("Checked %0d results, %0d with zero magnitude, over %0d cycles",
                 results_seen, zero_seen, cycle_count);
        if (error_count == 0)
            $display("quaternion_normalize_multiply test passed");
        else
            $display("quaternion_normalize_multiply test failed");
        $finish;
    end
endmodule
